/* rtl/core/srfp_pkg.sv */
// Shared types, phase codes, register indexes and byte markers for the reply frame parser.
package srfp_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_COMMAND     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_16BIT         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_BUFFER_SIZE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_BUFFER_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_BUFFER_SIZE   = 3'd4;

    localparam logic [2:0] PH_WAIT   = 3'd0;
    localparam logic [2:0] PH_ECHO   = 3'd1;
    localparam logic [2:0] PH_COUNT  = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_LEN_LO = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    localparam logic [7:0] START_BYTE = 8'hE0;
    localparam logic [7:0] ERROR_BYTE = 8'hEF;
    localparam logic [7:0] ECHO_FLAG  = 8'h80;

    typedef struct packed {
        logic [6:0]  expected_command;
        logic        length_16bit;
        logic [11:0] first_buffer_size;
        logic        second_buffer_enable;
        logic [15:0] second_buffer_size;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  responses_left;
        logic [7:0]  announced_count;
        logic [15:0] bytes_left;
        logic        in_second_buffer;
        logic [15:0] write_offset;
        logic [16:0] stored_total;
    } state_t;

    typedef struct packed {
        logic        store_valid;
        logic        store_buffer;
        logic [15:0] store_offset;
        logic [7:0]  store_byte;
        logic        frame_end;
        logic        frame_error;
        logic [16:0] total_stored;
        logic [7:0]  reply_count;
    } result_t;

endpackage

/* rtl/core/srfp_cfg_regs.sv */
// Configuration register file written over the index/data write channel.
module srfp_cfg_regs
    import srfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_COMMAND:     cfg_next.expected_command = cfg_data[6:0];
                CFG_LENGTH_16BIT:         cfg_next.length_16bit = cfg_data[0];
                CFG_FIRST_BUFFER_SIZE:    cfg_next.first_buffer_size = cfg_data[11:0];
                CFG_SECOND_BUFFER_ENABLE: cfg_next.second_buffer_enable = cfg_data[0];
                CFG_SECOND_BUFFER_SIZE:   cfg_next.second_buffer_size = cfg_data[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/srfp_step.sv */
// Next-state and result logic for one received reply byte.
module srfp_step
    import srfp_pkg::*;
(
    input  cfg_t       cfg,
    input  state_t     state,
    input  logic [7:0] rx_byte,
    output state_t     state_next,
    output result_t    result,
    output logic       has_result
);

    logic [15:0] buf_size;
    logic        can_store;
    logic        store_phase;
    logic [15:0] new_len;

    assign buf_size    = state.in_second_buffer ? cfg.second_buffer_size
                                                : {4'b0000, cfg.first_buffer_size};
    assign can_store   = state.write_offset < buf_size;
    assign store_phase = (state.phase == PH_LEN_HI) || (state.phase == PH_LEN_LO)
                      || (state.phase == PH_DATA);
    assign new_len     = {state.bytes_left[15:8], rx_byte};

    always_comb
    begin
        state_next = state;
        result     = '0;

        if (store_phase && can_store)
        begin
            result.store_valid      = 1'b1;
            result.store_buffer     = state.in_second_buffer;
            result.store_offset     = state.write_offset;
            result.store_byte       = rx_byte;
            state_next.write_offset = state.write_offset + 16'd1;
            state_next.stored_total = state.stored_total + 17'd1;
        end

        unique case (state.phase)
            PH_ECHO:
            begin
                if (rx_byte != ({1'b0, cfg.expected_command} | ECHO_FLAG))
                begin
                    result.frame_end   = 1'b1;
                    result.frame_error = 1'b1;
                    state_next.phase   = PH_WAIT;
                end
                else
                begin
                    state_next.phase = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                state_next.announced_count = rx_byte;
                state_next.responses_left  = rx_byte;
                if (rx_byte == 8'd0)
                begin
                    result.frame_end = 1'b1;
                    state_next.phase = PH_WAIT;
                end
                else
                begin
                    state_next.phase = cfg.length_16bit ? PH_LEN_HI : PH_LEN_LO;
                end
            end
            PH_LEN_HI:
            begin
                state_next.bytes_left = {rx_byte, 8'h00};
                state_next.phase      = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                state_next.bytes_left = new_len;
                if (!state.in_second_buffer && cfg.second_buffer_enable
                    && (state_next.write_offset >= {4'b0000, cfg.first_buffer_size}))
                begin
                    state_next.in_second_buffer = 1'b1;
                    state_next.write_offset     = 16'd0;
                end
                if (new_len == 16'd0)
                begin
                    state_next.responses_left = state.responses_left - 8'd1;
                    if (state_next.responses_left == 8'd0)
                    begin
                        result.frame_end = 1'b1;
                        state_next.phase = PH_WAIT;
                    end
                    else
                    begin
                        state_next.phase = cfg.length_16bit ? PH_LEN_HI : PH_LEN_LO;
                    end
                end
                else
                begin
                    state_next.phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                state_next.bytes_left = state.bytes_left - 16'd1;
                if (state_next.bytes_left == 16'd0)
                begin
                    state_next.responses_left = state.responses_left - 8'd1;
                    if (state_next.responses_left == 8'd0)
                    begin
                        result.frame_end = 1'b1;
                        state_next.phase = PH_WAIT;
                    end
                    else
                    begin
                        state_next.phase = cfg.length_16bit ? PH_LEN_HI : PH_LEN_LO;
                    end
                end
            end
            default:
            begin
                state_next.phase = PH_WAIT;
                if (rx_byte == START_BYTE)
                begin
                    state_next.announced_count  = 8'd0;
                    state_next.responses_left   = 8'd0;
                    state_next.bytes_left       = 16'd0;
                    state_next.stored_total     = 17'd0;
                    state_next.write_offset     = 16'd0;
                    state_next.in_second_buffer = 1'b0;
                    state_next.phase            = PH_ECHO;
                end
                else if (rx_byte == ERROR_BYTE)
                begin
                    state_next.announced_count = 8'd0;
                    state_next.stored_total    = 17'd0;
                    result.frame_end           = 1'b1;
                    result.frame_error         = 1'b1;
                end
            end
        endcase

        result.total_stored = state_next.stored_total;
        result.reply_count  = state_next.announced_count;
    end

    assign has_result = result.store_valid | result.frame_end;

endmodule

/* rtl/core/spi_reply_frame_parser_unit.sv */
// Reply frame parser top level: input word register, parse state, result register.
// A word waits in the input word register until the result register can take it.
// Throughput: one word per cycle, limited only by out_stall holding a result word.
// Words that cause no result are consumed without showing anything on the output.
// Reset (rst_n low, asynchronous) empties both registers, clears the registers
// written over the configuration channel and returns the parser to start-byte search.
module spi_reply_frame_parser_unit
    import srfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   store_valid,
    output logic                   store_buffer,
    output logic [15:0]            store_offset,
    output logic [7:0]             store_byte,
    output logic                   frame_end,
    output logic                   frame_error,
    output logic [16:0]            total_stored,
    output logic [7:0]             reply_count
);

    cfg_t       cfg;
    state_t     state_reg;
    state_t     state_next;
    result_t    result_reg;
    result_t    step_result;
    logic       step_has_result;
    logic       word_valid_reg;
    logic [7:0] word_reg;
    logic       out_valid_reg;
    logic       advance;

    srfp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srfp_step u_step
    (
        .cfg        (cfg),
        .state      (state_reg),
        .rx_byte    (word_reg),
        .state_next (state_next),
        .result     (step_result),
        .has_result (step_has_result)
    );

    assign advance  = word_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = word_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                word_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                word_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= step_has_result;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            word_reg <= rx_byte;
        end
        if (advance && step_has_result)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign store_valid  = result_reg.store_valid;
    assign store_buffer = result_reg.store_buffer;
    assign store_offset = result_reg.store_offset;
    assign store_byte   = result_reg.store_byte;
    assign frame_end    = result_reg.frame_end;
    assign frame_error  = result_reg.frame_error;
    assign total_stored = result_reg.total_stored;
    assign reply_count  = result_reg.reply_count;

endmodule

/* rtl/core/srfp_checker.sv */
// Port-level checker for the reply frame parser, bound to the top level.
module srfp_checker
    import srfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        store_valid,
    input logic        store_buffer,
    input logic [15:0] store_offset,
    input logic [7:0]  store_byte,
    input logic        frame_end,
    input logic        frame_error,
    input logic [16:0] total_stored
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(store_offset)
            && $stable(store_byte) && $stable(total_stored) && $stable(frame_end))
        else $error("stalled result word changed");

    a_word_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> store_valid || frame_end)
        else $error("result word without store or frame end");

    a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !store_valid |-> store_buffer == 1'b0 && store_offset == 16'd0
            && store_byte == 8'd0)
        else $error("store fields not cleared on a word without store");

    a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_error |-> frame_end)
        else $error("frame error without frame end");

    a_first_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_valid && !store_buffer |-> store_offset < 16'd4095)
        else $error("first buffer offset beyond its largest size");

endmodule

bind spi_reply_frame_parser_unit srfp_checker u_srfp_checker (.*);

/* sim/spi_reply_frame_parser_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the SPI reply frame parser: directed table and random frames.
module spi_reply_frame_parser_unit_tb;
    import srfp_pkg::*;

    localparam int PIPE_SETTLE   = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_WORDS   = 130;
    localparam int PAUSE_AT      = 65;
    localparam int DIRECTED_ROWS = 18;
    localparam int CFG_SPLIT     = 8;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic       has_reply;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_REPLY = '0;
    localparam result_t END_ERR  = {1'b0, 1'b0, 16'd0, 8'd0, 1'b1, 1'b1, 17'd0, 8'd0};
    localparam result_t END_OK   = {1'b0, 1'b0, 16'd0, 8'd0, 1'b1, 1'b0, 17'd0, 8'd0};

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [7:0]             rx_byte   = 8'd0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   store_valid;
    logic                   store_buffer;
    logic [15:0]            store_offset;
    logic [7:0]             store_byte;
    logic                   frame_end;
    logic                   frame_error;
    logic [16:0]            total_stored;
    logic [7:0]             reply_count;

    cfg_t    frame_regs  = '0;
    state_t  frame_state = '0;
    result_t pending_replies [$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      idle_pct       = 0;
    int      stall_pct      = 0;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        {8'h00,      1'b1, 1'b0, NO_REPLY},
        {8'hFF,      1'b1, 1'b0, NO_REPLY},
        {ERROR_BYTE, 1'b1, 1'b1, END_ERR},
        {START_BYTE, 1'b1, 1'b0, NO_REPLY},
        {8'h81,      1'b1, 1'b1, END_ERR},
        {START_BYTE, 1'b1, 1'b0, NO_REPLY},
        {ECHO_FLAG,  1'b1, 1'b0, NO_REPLY},
        {8'h00,      1'b1, 1'b1, END_OK},
        {START_BYTE, 1'b0, 1'b0, NO_REPLY},
        {8'hFF,      1'b0, 1'b0, NO_REPLY},
        {8'h03,      1'b0, 1'b0, NO_REPLY},
        {8'h02,      1'b0, 1'b0, NO_REPLY},
        {8'h00,      1'b0, 1'b0, NO_REPLY},
        {8'hFF,      1'b0, 1'b0, NO_REPLY},
        {8'h00,      1'b0, 1'b0, NO_REPLY},
        {8'h01,      1'b0, 1'b0, NO_REPLY},
        {8'h55,      1'b0, 1'b0, NO_REPLY},
        {ERROR_BYTE, 1'b0, 1'b0, NO_REPLY}
    };

    spi_reply_frame_parser_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .store_valid  (store_valid),
        .store_buffer (store_buffer),
        .store_offset (store_offset),
        .store_byte   (store_byte),
        .frame_end    (frame_end),
        .frame_error  (frame_error),
        .total_stored (total_stored),
        .reply_count  (reply_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic store_word(input logic [7:0] b, inout result_t r);
        logic [15:0] room;
        room = frame_state.in_second_buffer ? frame_regs.second_buffer_size
                                            : {4'd0, frame_regs.first_buffer_size};
        if (frame_state.write_offset < room)
        begin
            r.store_valid  = 1'b1;
            r.store_buffer = frame_state.in_second_buffer;
            r.store_offset = frame_state.write_offset;
            r.store_byte   = b;
            frame_state.write_offset = frame_state.write_offset + 16'd1;
            frame_state.stored_total = frame_state.stored_total + 17'd1;
        end
    endtask

    task automatic close_response(inout result_t r);
        frame_state.responses_left = frame_state.responses_left - 8'd1;
        if (frame_state.responses_left == 8'd0)
        begin
            r.frame_end       = 1'b1;
            frame_state.phase = PH_WAIT;
        end
        else
        begin
            frame_state.phase = frame_regs.length_16bit ? PH_LEN_HI : PH_LEN_LO;
        end
    endtask

    task automatic parse_step(input logic [7:0] b, output logic has, output result_t r);
        r = NO_REPLY;
        case (frame_state.phase)
            PH_ECHO:
            begin
                if (b != ({1'b0, frame_regs.expected_command} | ECHO_FLAG))
                begin
                    r.frame_end       = 1'b1;
                    r.frame_error     = 1'b1;
                    frame_state.phase = PH_WAIT;
                end
                else
                begin
                    frame_state.phase = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                frame_state.announced_count = b;
                frame_state.responses_left  = b;
                if (b == 8'd0)
                begin
                    r.frame_end       = 1'b1;
                    frame_state.phase = PH_WAIT;
                end
                else
                begin
                    frame_state.phase = frame_regs.length_16bit ? PH_LEN_HI : PH_LEN_LO;
                end
            end
            PH_LEN_HI:
            begin
                store_word(b, r);
                frame_state.bytes_left = {b, 8'h00};
                frame_state.phase      = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                store_word(b, r);
                frame_state.bytes_left[7:0] = b;
                if (!frame_state.in_second_buffer && frame_regs.second_buffer_enable &&
                    frame_state.write_offset >= {4'd0, frame_regs.first_buffer_size})
                begin
                    frame_state.in_second_buffer = 1'b1;
                    frame_state.write_offset     = 16'd0;
                end
                if (frame_state.bytes_left == 16'd0)
                    close_response(r);
                else
                    frame_state.phase = PH_DATA;
            end
            PH_DATA:
            begin
                store_word(b, r);
                frame_state.bytes_left = frame_state.bytes_left - 16'd1;
                if (frame_state.bytes_left == 16'd0)
                    close_response(r);
            end
            default:
            begin
                frame_state.phase = PH_WAIT;
                if (b == START_BYTE)
                begin
                    frame_state.announced_count  = 8'd0;
                    frame_state.responses_left   = 8'd0;
                    frame_state.bytes_left       = 16'd0;
                    frame_state.stored_total     = 17'd0;
                    frame_state.write_offset     = 16'd0;
                    frame_state.in_second_buffer = 1'b0;
                    frame_state.phase            = PH_ECHO;
                end
                else if (b == ERROR_BYTE)
                begin
                    frame_state.announced_count = 8'd0;
                    frame_state.stored_total    = 17'd0;
                    r.frame_end                 = 1'b1;
                    r.frame_error               = 1'b1;
                end
            end
        endcase
        has            = r.store_valid || r.frame_end;
        r.total_stored = frame_state.stored_total;
        r.reply_count  = frame_state.announced_count;
    endtask

    function automatic logic [7:0] next_reply_word();
        int         roll;
        logic [7:0] echo_ok;
        roll    = $urandom_range(0, 99);
        echo_ok = {1'b0, frame_regs.expected_command} | ECHO_FLAG;
        case (frame_state.phase)
            PH_ECHO:   return (roll < 85) ? echo_ok : 8'($urandom);
            PH_COUNT:
            begin
                if (roll < 8)
                    return 8'h00;
                else if (roll < 10)
                    return 8'hFF;
                return 8'($urandom_range(1, 4));
            end
            PH_LEN_HI: return (frame_state.responses_left > 8 || roll >= 5) ? 8'h00 : 8'h01;
            PH_LEN_LO:
            begin
                if (frame_state.responses_left > 8)
                    return 8'($urandom_range(0, 1));
                else if (roll < 2)
                    return 8'hFF;
                else if (roll < 15)
                    return 8'($urandom_range(9, 40));
                return 8'($urandom_range(0, 8));
            end
            PH_DATA:   return 8'($urandom);
            default:
            begin
                if (roll < 70)
                    return START_BYTE;
                else if (roll < 78)
                    return ERROR_BYTE;
                return 8'($urandom);
            end
        endcase
    endfunction

    task automatic send_word(input logic [7:0] b, input logic typed, input logic typed_has,
                             input result_t typed_want);
        logic    has;
        result_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        parse_step(b, has, r);
        if (typed)
        begin
            has = typed_has;
            r   = typed_want;
        end
        if (has)
            pending_replies.push_back(r);
    endtask

    task automatic settle_replies(input logic with_pipe);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
        if (with_pipe)
            repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic program_regs(input logic [6:0] cmd, input logic len16, input logic [11:0] first,
                                input logic en, input logic [15:0] second);
        logic [CFG_INDEX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0]  val [5];
        int                     i;
        idx[0] = CFG_EXPECTED_COMMAND;     val[0] = 16'(cmd);
        idx[1] = CFG_LENGTH_16BIT;         val[1] = 16'(len16);
        idx[2] = CFG_FIRST_BUFFER_SIZE;    val[2] = 16'(first);
        idx[3] = CFG_SECOND_BUFFER_ENABLE; val[3] = 16'(en);
        idx[4] = CFG_SECOND_BUFFER_SIZE;   val[4] = second;
        cfg_valid <= 1'b1;
        for (i = 0; i < 5; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                CFG_EXPECTED_COMMAND:     frame_regs.expected_command     = val[i][6:0];
                CFG_LENGTH_16BIT:         frame_regs.length_16bit         = val[i][0];
                CFG_FIRST_BUFFER_SIZE:    frame_regs.first_buffer_size    = val[i][11:0];
                CFG_SECOND_BUFFER_ENABLE: frame_regs.second_buffer_enable = val[i][0];
                CFG_SECOND_BUFFER_SIZE:   frame_regs.second_buffer_size   = val[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string fname, input logic [16:0] want, input logic [16:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin : reply_check
        result_t want;
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {store_valid, store_buffer, store_offset, store_byte,
                   frame_end, frame_error, total_stored, reply_count};
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, got %h", $time, got);
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("store_valid", 17'(want.store_valid), 17'(got.store_valid));
                check_field("store_buffer", 17'(want.store_buffer), 17'(got.store_buffer));
                check_field("store_offset", 17'(want.store_offset), 17'(got.store_offset));
                check_field("store_byte", 17'(want.store_byte), 17'(got.store_byte));
                check_field("frame_end", 17'(want.frame_end), 17'(got.frame_end));
                check_field("frame_error", 17'(want.frame_error), 17'(got.frame_error));
                check_field("total_stored", want.total_stored, got.total_stored);
                check_field("reply_count", 17'(want.reply_count), 17'(got.reply_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("spi_reply_frame_parser_unit_tb: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int i;
        int p;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (i == CFG_SPLIT)
            begin
                settle_replies(1'b1);
                program_regs(7'h7F, 1'b0, 12'd3, 1'b1, 16'd2);
            end
            send_word(directed_rows[i].rx, directed_rows[i].typed,
                      directed_rows[i].has_reply, directed_rows[i].want);
        end

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            settle_replies(1'b1);
            if (p == 0)
                program_regs(7'd0, 1'b0, 12'd0, 1'b0, 16'd0);
            else if (p == 1)
                program_regs(7'h7F, 1'b1, 12'hFFF, 1'b1, 16'hFFFF);
            else
                program_regs(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                             12'($urandom_range(0, 12)), 1'($urandom_range(0, 1)),
                             16'($urandom_range(0, 20)));
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct <= 0;  end
                1:       begin idle_pct = 59; stall_pct <= 0;  end
                2:       begin idle_pct = 0;  stall_pct <= 59; end
                default: begin idle_pct = 38; stall_pct <= 38; end
            endcase
            for (i = 0; i < PHASE_WORDS; i++)
            begin
                if (i == PAUSE_AT)
                    settle_replies(1'b0);
                send_word(next_reply_word(), 1'b0, 1'b0, NO_REPLY);
            end
        end

        // finish the open frame
        idle_pct = 0;
        stall_pct <= 0;
        while (frame_state.phase != PH_WAIT)
            send_word(next_reply_word(), 1'b0, 1'b0, NO_REPLY);

        settle_replies(1'b1);
        if (mismatch_count == 0)
            $display("spi_reply_frame_parser_unit_tb: done, clean");
        else
            $display("spi_reply_frame_parser_unit_tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/srfp_pkg.sv
rtl/core/srfp_cfg_regs.sv
rtl/core/srfp_step.sv
rtl/core/spi_reply_frame_parser_unit.sv
rtl/core/srfp_checker.sv
sim/spi_reply_frame_parser_unit_tb.sv
